[hw/rtl/multi_stack_shared_pool_core_macros.svh]
// Assertion helpers used by the RTL top level.
`ifndef MULTI_STACK_SHARED_POOL_CORE_MACROS_SVH
`define MULTI_STACK_SHARED_POOL_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSP_ASSERT_IMPLY(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error("multi_stack_shared_pool_core: assertion failed");

// Next-cycle implication, checked out of reset.
`define MSP_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error("multi_stack_shared_pool_core: assertion failed");

`endif

[hw/rtl/msp_pkg.sv]
`timescale 1ns / 1ps

package msp_pkg;

    localparam int VALUE_W     = 32;
    localparam int SIDX_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } msp_cmd_t;

    typedef struct packed {
        logic out_free;
    } msp_stat_t;

endpackage

[hw/rtl/msp_ram.sv]
`timescale 1ns / 1ps

module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/msp_ctrl.sv]
`timescale 1ns / 1ps

module msp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  msp_pkg::msp_stat_t stat,
    output msp_pkg::msp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/msp_datapath.sv]
`timescale 1ns / 1ps

module msp_datapath #(
    parameter int NUM_STACKS = 4,
    parameter int POOL_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msp_pkg::msp_cmd_t               cmd,
    output msp_pkg::msp_stat_t              stat,
    input  logic                            in_opcode,
    input  logic [msp_pkg::SIDX_W-1:0]      in_stack_index,
    input  logic [msp_pkg::VALUE_W-1:0]     in_push_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [msp_pkg::STATUS_W-1:0]    out_status,
    output logic [msp_pkg::VALUE_W-1:0]     out_pop_value
);

    localparam int LW  = $clog2(POOL_SLOTS + 1);
    localparam int AW  = $clog2(POOL_SLOTS);
    localparam int SIW = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);
    localparam logic [LW-1:0] LAST_SLOT = LW'(POOL_SLOTS - 1);

    logic                          op_reg;
    logic [msp_pkg::SIDX_W-1:0]    sidx_reg;
    logic [msp_pkg::VALUE_W-1:0]   val_reg;
    logic                          range_ok_reg;
    logic [LW-1:0]                 free_head_reg;
    logic [LW-1:0]                 fill_reg;
    logic [NUM_STACKS-1:0]         top_valid_reg;
    logic [LW-1:0]                 top_reg;
    logic [LW-1:0]                 lk_addr_reg;
    logic                          out_valid_reg;
    logic [msp_pkg::STATUS_W-1:0]  out_status_reg;
    logic [msp_pkg::VALUE_W-1:0]   out_value_reg;

    logic [SIW-1:0]                sidx_s;
    logic [LW-1:0]                 tops_rdata;
    logic [LW-1:0]                 links_rdata;
    logic [msp_pkg::VALUE_W-1:0]   values_rdata;
    logic [LW-1:0]                 top_eff;
    logic [LW-1:0]                 lk_rd_addr;
    logic [LW-1:0]                 link_eff;
    logic [LW-1:0]                 lk_succ;
    logic                          push_ok;
    logic                          pop_ok;
    logic                          in_range;

    logic                          tops_en;
    logic                          tops_we;
    logic [SIW-1:0]                tops_addr;
    logic [LW-1:0]                 tops_wdata;
    logic                          links_en;
    logic                          links_we;
    logic [AW-1:0]                 links_addr;
    logic [LW-1:0]                 links_wdata;
    logic                          values_en;
    logic                          values_we;
    logic [AW-1:0]                 values_addr;

    assign sidx_s   = SIW'(sidx_reg);
    assign in_range = 32'(in_stack_index) < NUM_STACKS;

    // Stack top, taken as empty for an absent stack or until the stack's entry has been written.
    assign top_eff = (range_ok_reg && top_valid_reg[sidx_s]) ? tops_rdata : NULL_LINK;
    assign lk_rd_addr = (op_reg == msp_pkg::OP_POP) ? top_eff : free_head_reg;

    // Slots at or above the fill mark are taken as still linking to the next slot.
    assign lk_succ  = (lk_addr_reg == LAST_SLOT) ? NULL_LINK : LW'(lk_addr_reg + 1'b1);
    assign link_eff = (lk_addr_reg >= fill_reg) ? lk_succ : links_rdata;

    assign push_ok = (op_reg == msp_pkg::OP_PUSH) && range_ok_reg &&
                     (free_head_reg != NULL_LINK);
    assign pop_ok  = (op_reg == msp_pkg::OP_POP) && (top_reg != NULL_LINK);

    always_comb
    begin
        tops_en    = cmd.load || (cmd.commit && (push_ok || pop_ok));
        tops_we    = cmd.commit;
        tops_addr  = cmd.commit ? sidx_s : SIW'(in_stack_index);
        tops_wdata = push_ok ? free_head_reg : link_eff;

        links_en    = cmd.lookup || (cmd.commit && (push_ok || pop_ok));
        links_we    = cmd.commit;
        links_addr  = cmd.commit ? (push_ok ? AW'(free_head_reg) : AW'(top_reg))
                                 : AW'(lk_rd_addr);
        links_wdata = push_ok ? top_reg : free_head_reg;

        values_en   = cmd.lookup || (cmd.commit && push_ok);
        values_we   = cmd.commit;
        values_addr = cmd.commit ? AW'(free_head_reg) : AW'(top_eff);
    end

    msp_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_STACKS)
    ) u_tops (
        .clk   (clk),
        .en    (tops_en),
        .we    (tops_we),
        .addr  (tops_addr),
        .wdata (tops_wdata),
        .rdata (tops_rdata)
    );

    msp_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_links (
        .clk   (clk),
        .en    (links_en),
        .we    (links_we),
        .addr  (links_addr),
        .wdata (links_wdata),
        .rdata (links_rdata)
    );

    msp_ram #(
        .WIDTH (msp_pkg::VALUE_W),
        .DEPTH (POOL_SLOTS)
    ) u_values (
        .clk   (clk),
        .en    (values_en),
        .we    (values_we),
        .addr  (values_addr),
        .wdata (val_reg),
        .rdata (values_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_opcode;
            sidx_reg     <= in_stack_index;
            val_reg      <= in_push_value;
            range_ok_reg <= in_range;
        end
        if (cmd.lookup)
        begin
            top_reg     <= top_eff;
            lk_addr_reg <= lk_rd_addr;
        end
        if (cmd.commit)
        begin
            if (op_reg == msp_pkg::OP_PUSH)
            begin
                out_status_reg <= push_ok ? msp_pkg::ST_DONE : msp_pkg::ST_FULL;
                out_value_reg  <= '0;
            end
            else
            begin
                out_status_reg <= pop_ok ? msp_pkg::ST_DONE : msp_pkg::ST_EMPTY;
                out_value_reg  <= pop_ok ? values_rdata : '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fill_reg      <= '0;
            top_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && push_ok)
            begin
                free_head_reg          <= link_eff;
                top_valid_reg[sidx_s]  <= 1'b1;
                if (free_head_reg == fill_reg)
                begin
                    fill_reg <= LW'(fill_reg + 1'b1);
                end
            end
            else if (cmd.commit && pop_ok)
            begin
                free_head_reg <= top_reg;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_pop_value = out_value_reg;

endmodule

[hw/rtl/multi_stack_shared_pool_core.sv]
`timescale 1ns / 1ps

// NUM_STACKS LIFO stacks sharing a pool of POOL_SLOTS slots, linked through a free list.
// Each request (push or pop) passes the accept, read and write states: accept reads the
// stack's top, read fetches the slot's link and value, and write waits until the result
// register is free or being taken, then loads it and, on success, writes links, top and
// free head, plus the value for a push. A new request is accepted only once the previous
// one is in the result register, which may still await taking. Memories come up usable
// straight out of reset: no clearing pass; untouched links follow a fill mark instead.
// Status 1 flags a push into a full pool or to a stack number at or above NUM_STACKS;
// status 2 flags a pop from an empty or absent stack and returns -1.

`include "multi_stack_shared_pool_core_macros.svh"

module multi_stack_shared_pool_core #(
    parameter int NUM_STACKS = 4,
    parameter int POOL_SLOTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [msp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // stack_index, push_value, pad
    input  logic [0:0]                          s_axis_tuser,   // opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [msp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // pop_value
    output logic [msp_pkg::STATUS_W-1:0]        m_axis_tuser    // status
);

    msp_pkg::msp_cmd_t  cmd;
    msp_pkg::msp_stat_t stat;

    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msp_datapath #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_opcode      (s_axis_tuser[0]),
        .in_stack_index (s_axis_tdata[msp_pkg::SIDX_W-1:0]),
        .in_push_value  (s_axis_tdata[msp_pkg::SIDX_W +: msp_pkg::VALUE_W]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (m_axis_tuser),
        .out_pop_value  (m_axis_tdata)
    );

    `MSP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MSP_ASSERT_IMPLY(a_full_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == msp_pkg::ST_FULL), m_axis_tdata == '0)
    `MSP_ASSERT_IMPLY(a_empty_ones, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == msp_pkg::ST_EMPTY), m_axis_tdata == '1)
    `MSP_ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid,
        (m_axis_tuser == msp_pkg::ST_DONE) || (m_axis_tuser == msp_pkg::ST_FULL) ||
        (m_axis_tuser == msp_pkg::ST_EMPTY))

endmodule
